// ===== hdl/fdc_pkg.sv =====
// Package for the two-drive nibble floppy controller.
// Types, geometry constants and switch codes; no dependencies.
package fdc_pkg;
  localparam int TRACK_COUNT     = 35;
  localparam int BYTES_PER_TRACK = 6656;
  localparam int OFF_DELAY       = 32768;
  localparam int SIDE_BYTES      = TRACK_COUNT * BYTES_PER_TRACK;
  localparam int STORE_DEPTH     = 2 * SIDE_BYTES;
  localparam int STORE_AW        = $clog2(STORE_DEPTH);
  localparam logic [6:0] TOP_HALF = 7'(2 * TRACK_COUNT - 1);

  localparam logic [1:0] KIND_BUS  = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_LOAD = 2'd2;

  localparam logic [3:0] SW_MOTOR_OFF = 4'h8;
  localparam logic [3:0] SW_MOTOR_ON  = 4'h9;
  localparam logic [3:0] SW_DRIVE0    = 4'ha;
  localparam logic [3:0] SW_DRIVE1    = 4'hb;
  localparam logic [3:0] SW_SHIFT     = 4'hc;
  localparam logic [3:0] SW_LOAD      = 4'hd;
  localparam logic [3:0] SW_SENSE     = 4'he;
  localparam logic [3:0] SW_WRITE     = 4'hf;

  localparam logic [1:0] REG_TICK_PERIOD   = 2'd0;
  localparam logic [1:0] REG_WRITE_PROTECT = 2'd1;
  localparam logic [1:0] REG_DISK_PRESENT  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  switch_offset;
    logic        is_write;
    logic [7:0]  write_value;
    logic        load_drive;
    logic [17:0] load_address;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       motor_on;
    logic       selected_drive;
    logic [1:0] dirty_flags;
    logic [6:0] head_position;
  } rsp_t;

  // Phase bits to target quarter position; valid flag in bit 2.
  function automatic logic [2:0] phase_target(input logic [3:0] p);
    case (p)
      4'h1: phase_target = 3'b100;
      4'h2: phase_target = 3'b101;
      4'h4: phase_target = 3'b110;
      4'h8: phase_target = 3'b111;
      default: phase_target = 3'b000;
    endcase
  endfunction

  function automatic logic [6:0] step_head(input logic [6:0] ht, input logic [3:0] p);
    logic [2:0] t;
    logic [1:0] dlt;
    logic [6:0] r;
    t = phase_target(p);
    dlt = t[1:0] - ht[1:0];
    r = ht;
    if (t[2]) begin
      if (dlt == 2'd1 && ht != TOP_HALF) r = ht + 7'd1;
      else if (dlt == 2'd3 && ht != 7'd0) r = ht - 7'd1;
    end
    return r;
  endfunction
endpackage

// ===== hdl/fdc_stream_if.sv =====
// Valid/ready channel carrying one payload of type T.
// The payload type is a parameter; no package dependency.
interface fdc_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fdc_front.sv =====
// Front end: request intake and a two-entry queue toward the back end.
// Depends on fdc_pkg.
module fdc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fdc_pkg::req_t       in_data,
  output logic                q_valid,
  input  logic                q_ready,
  output fdc_pkg::req_t       q_data
);
  fdc_pkg::req_t slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_data   = slot[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_data;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== hdl/fdc_back.sv =====
// Back end: controller state, disk store and result register.
// Depends on fdc_pkg.
module fdc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [16:0]   cfg_data,
  input  logic          q_valid,
  output logic          q_ready,
  input  fdc_pkg::req_t q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fdc_pkg::rsp_t out_data
);
  logic [16:0] tick_period;
  logic [1:0]  write_protect, disk_present;
  logic [7:0]  data_latch, write_request_latch;
  logic        pending_write_valid;
  logic [7:0]  pending_write_value;
  logic        pending_write_drive;
  logic [5:0]  pending_write_track;
  logic [12:0] pending_write_byte;
  logic [16:0] tick_delay;
  logic        motor_running, drive_choice, off_pending, write_mode;
  logic [15:0] off_counter;
  logic [3:0]  phase_bits [2];
  logic [6:0]  half_track [2];
  logic [12:0] byte_position [2];
  logic [1:0]  dirty_marks;

  logic [7:0] store_mem [fdc_pkg::STORE_DEPTH];

  // Store reads are registered; the latch fill is held until the data returns.
  logic       fill_pend;
  logic [7:0] store_q;

  logic        go, stall_out;
  logic        d;
  logic [12:0] nb;
  logic [18:0] rd_addr, wr_addr;
  logic        rd_en, wr_en;
  logic [7:0]  wr_val;
  logic [7:0]  latch_cur;
  fdc_pkg::rsp_t rsp;

  // The fill must land before the next request reads the latch.
  assign stall_out = out_valid && !out_ready;
  assign q_ready = !stall_out && !fill_pend;
  assign go = q_valid && q_ready;
  assign d = drive_choice;
  assign latch_cur = data_latch;

  always_comb begin
    nb = (byte_position[d] == 13'(fdc_pkg::BYTES_PER_TRACK - 1)) ? 13'd0
         : byte_position[d] + 13'd1;
    rd_addr = 19'(d ? fdc_pkg::SIDE_BYTES : 0)
              + 19'(half_track[d][6:1]) * 19'(fdc_pkg::BYTES_PER_TRACK) + 19'(nb);
    wr_addr = 19'(pending_write_drive ? fdc_pkg::SIDE_BYTES : 0)
              + 19'(pending_write_track) * 19'(fdc_pkg::BYTES_PER_TRACK)
              + 19'(pending_write_byte);
    wr_val = pending_write_value;
    rd_en = 1'b0;
    wr_en = 1'b0;
    if (go && q_data.kind == fdc_pkg::KIND_TICK && tick_delay == 17'd0) begin
      rd_en = motor_running && disk_present[d] && !write_mode
              && half_track[d][6:1] < 6'(fdc_pkg::TRACK_COUNT);
      wr_en = pending_write_valid && disk_present[pending_write_drive]
              && pending_write_track < 6'(fdc_pkg::TRACK_COUNT);
    end
    if (go && q_data.kind == fdc_pkg::KIND_LOAD
        && q_data.load_address < 18'(fdc_pkg::SIDE_BYTES)) begin
      wr_en = 1'b1;
      wr_addr = 19'(q_data.load_drive ? fdc_pkg::SIDE_BYTES : 0) + 19'(q_data.load_address);
      wr_val = q_data.write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr[fdc_pkg::STORE_AW-1:0]] <= wr_val;
    if (rd_en) store_q <= store_mem[rd_addr[fdc_pkg::STORE_AW-1:0]];
  end

  always_comb begin
    logic [3:0] bitm;
    logic [3:0] pb;
    bitm = 4'b0001 << q_data.switch_offset[2:1];
    pb = q_data.switch_offset[0] ? (phase_bits[d] | bitm) : (phase_bits[d] & ~bitm);
    rsp.read_data = 8'd0;
    if (q_data.kind == fdc_pkg::KIND_BUS) begin
      if (q_data.switch_offset == fdc_pkg::SW_SENSE && motor_running)
        rsp.read_data = {write_protect[d], latch_cur[6:0]};
      else
        rsp.read_data = latch_cur;
    end
    rsp.motor_on = motor_running;
    rsp.selected_drive = drive_choice;
    rsp.dirty_flags = dirty_marks;
    rsp.head_position = half_track[drive_choice];
    if (q_data.kind == fdc_pkg::KIND_BUS) begin
      case (q_data.switch_offset)
        fdc_pkg::SW_MOTOR_ON: rsp.motor_on = 1'b1;
        fdc_pkg::SW_DRIVE0, fdc_pkg::SW_DRIVE1: begin
          rsp.selected_drive = q_data.switch_offset[0];
          rsp.head_position = half_track[q_data.switch_offset[0]];
          if (motor_running && q_data.switch_offset[0] != drive_choice) rsp.dirty_flags = 2'b00;
        end
        default: begin
          if (q_data.switch_offset inside {[4'h0:4'h7]} && motor_running)
            rsp.head_position = fdc_pkg::step_head(half_track[d], pb);
        end
      endcase
    end else if (q_data.kind == fdc_pkg::KIND_TICK && tick_delay == 17'd0) begin
      if (wr_en) rsp.dirty_flags[pending_write_drive] = 1'b1;
      if (off_pending && off_counter == 16'(fdc_pkg::OFF_DELAY)) begin
        rsp.motor_on = 1'b0;
        rsp.dirty_flags = 2'b00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= 17'd31;
      write_protect <= 2'd0;
      disk_present <= 2'd0;
      data_latch <= 8'd0;
      write_request_latch <= 8'd0;
      pending_write_valid <= 1'b0;
      pending_write_value <= 8'd0;
      pending_write_drive <= 1'b0;
      pending_write_track <= 6'd0;
      pending_write_byte <= 13'd0;
      tick_delay <= 17'd0;
      motor_running <= 1'b0;
      drive_choice <= 1'b0;
      off_pending <= 1'b0;
      off_counter <= 16'd0;
      write_mode <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        phase_bits[i] <= 4'd0;
        half_track[i] <= fdc_pkg::TOP_HALF;
        byte_position[i] <= 13'd0;
      end
      dirty_marks <= 2'd0;
      fill_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fdc_pkg::REG_TICK_PERIOD: tick_period <= cfg_data;
          fdc_pkg::REG_WRITE_PROTECT: write_protect <= cfg_data[1:0];
          fdc_pkg::REG_DISK_PRESENT: disk_present <= cfg_data[1:0];
          default: ;
        endcase
      end
      fill_pend <= rd_en;
      if (fill_pend) data_latch <= store_q;
      if (out_ready) out_valid <= 1'b0;
      if (go) begin
        out_valid <= 1'b1;
        out_data <= rsp;
        motor_running <= rsp.motor_on;
        drive_choice <= rsp.selected_drive;
        dirty_marks <= rsp.dirty_flags;
        case (q_data.kind)
          fdc_pkg::KIND_BUS: begin
            if (data_latch[7]) data_latch <= 8'd0;
            if (q_data.is_write && motor_running
                && (q_data.switch_offset == fdc_pkg::SW_LOAD
                    || q_data.switch_offset == fdc_pkg::SW_WRITE))
              write_request_latch <= q_data.write_value;
            case (q_data.switch_offset)
              fdc_pkg::SW_MOTOR_OFF: begin
                if (motor_running && !off_pending) begin
                  off_pending <= 1'b1;
                  off_counter <= 16'd0;
                end
              end
              fdc_pkg::SW_MOTOR_ON: begin
                if (!motor_running) tick_delay <= 17'd0;
                off_pending <= 1'b0;
              end
              fdc_pkg::SW_DRIVE0, fdc_pkg::SW_DRIVE1: begin
                if (q_data.switch_offset[0] != drive_choice) begin
                  off_pending <= 1'b0;
                  if (motor_running) tick_delay <= 17'd0;
                end
              end
              fdc_pkg::SW_SHIFT: begin
                if (write_mode && motor_running && disk_present[d]) begin
                  pending_write_valid <= 1'b1;
                  pending_write_value <= write_request_latch;
                  pending_write_drive <= d;
                  pending_write_track <= half_track[d][6:1];
                  pending_write_byte <= nb;
                end
              end
              fdc_pkg::SW_LOAD: ;
              fdc_pkg::SW_SENSE: write_mode <= 1'b0;
              fdc_pkg::SW_WRITE: write_mode <= 1'b1;
              default: begin
                if (motor_running) begin
                  phase_bits[d][q_data.switch_offset[2:1]] <= q_data.switch_offset[0];
                  half_track[d] <= rsp.head_position;
                end
              end
            endcase
          end
          fdc_pkg::KIND_TICK: begin
            if (tick_delay != 17'd0) begin
              tick_delay <= tick_delay - 17'd1;
            end else begin
              if (motor_running && disk_present[d]) byte_position[d] <= nb;
              if (pending_write_valid) begin
                pending_write_valid <= 1'b0;
                pending_write_value <= 8'd0;
                pending_write_drive <= 1'b0;
                pending_write_track <= 6'd0;
                pending_write_byte <= 13'd0;
              end
              if (off_pending) begin
                if (off_counter == 16'(fdc_pkg::OFF_DELAY)) off_pending <= 1'b0;
                else off_counter <= off_counter + 16'd1;
              end
              tick_delay <= (tick_period == 17'd0) ? 17'd0 : tick_period - 17'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== hdl/floppy_controller_soft_switches.sv =====
// Two-drive nibble floppy controller soft switches, top level.
// Requests pass the front queue and the registered back end; one request per cycle while the
// output is not stalled; a read tick in read mode holds the next request for the store read.
// Reset: synchronous on rst; state to power-on values, store contents undefined.
// Depends on fdc_pkg, fdc_stream_if, fdc_front, fdc_back.
module floppy_controller_soft_switches (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  fdc_stream_if.sink   in_ch,
  fdc_stream_if.source out_ch
);
  logic          q_valid, q_ready;
  fdc_pkg::req_t q_data;

  fdc_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  fdc_back u_back (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

// ===== tb/sv/tb_floppy_controller_soft_switches.sv =====
// Testbench for the two-drive nibble floppy controller soft switches.
// Predicts every result from its own model of the controller; depends on fdc_pkg, fdc_stream_if.
`timescale 1ns / 100ps

module tb_floppy_controller_soft_switches;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  fdc_stream_if #(.T(fdc_pkg::req_t)) in_ch (clk);
  fdc_stream_if #(.T(fdc_pkg::rsp_t)) out_ch (clk);

  floppy_controller_soft_switches i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fdc_pkg::req_t req_queue[$];
  fdc_pkg::rsp_t expected_rsps[$];
  bit   hold_requests = 1'b0;
  bit   idle_en = 1'b1;
  int   mismatch_count = 0;
  int   quiet_cycles = 0;

  // ---- controller model, stepped as requests are queued ----
  logic [16:0] m_period;
  logic [1:0]  m_wprot, m_present;
  logic [7:0]  m_latch, m_wreq;
  bit          m_pw_valid;
  logic [7:0]  m_pw_value;
  bit          m_pw_drive;
  logic [5:0]  m_pw_track;
  logic [12:0] m_pw_byte;
  logic [16:0] m_delay;
  bit          m_motor, m_drive, m_off_pend, m_wmode;
  logic [15:0] m_off_cnt;
  logic [3:0]  m_phase[2];
  int          m_half[2];
  int          m_pos[2];
  bit          m_dirty[2];
  logic [7:0]  disk_img[int];

  function automatic void model_reset();
    m_period = 17'd31; m_wprot = '0; m_present = '0;
    m_latch = '0; m_wreq = '0; m_pw_valid = 0; m_pw_value = '0; m_pw_drive = 0;
    m_pw_track = '0; m_pw_byte = '0; m_delay = '0; m_motor = 0; m_drive = 0;
    m_off_pend = 0; m_off_cnt = '0; m_wmode = 0;
    for (int d = 0; d < 2; d++) begin
      m_phase[d] = '0; m_half[d] = int'(fdc_pkg::TOP_HALF); m_pos[d] = 0; m_dirty[d] = 0;
    end
  endfunction

  function automatic void motor_stop();
    if (m_motor) begin
      m_motor = 0; m_off_pend = 0; m_dirty[0] = 0; m_dirty[1] = 0;
    end
  endfunction

  function automatic void move_head();
    int tgt, dlt;
    case (m_phase[m_drive])
      4'h1: tgt = 0;
      4'h2: tgt = 1;
      4'h4: tgt = 2;
      4'h8: tgt = 3;
      default: tgt = -1;
    endcase
    if (tgt < 0) return;
    dlt = tgt - (m_half[m_drive] & 3);
    if (dlt == 1 || dlt == -1) m_half[m_drive] += dlt;
    else if (dlt == 3) m_half[m_drive] -= 1;
    else if (dlt == -3) m_half[m_drive] += 1;
    if (m_half[m_drive] < 0) m_half[m_drive] = 0;
    else if (m_half[m_drive] > int'(fdc_pkg::TOP_HALF)) m_half[m_drive] = int'(fdc_pkg::TOP_HALF);
  endfunction

  function automatic void select_drive(bit nxt);
    if (nxt == m_drive) return;
    m_off_pend = 0;
    if (m_motor) begin
      motor_stop();
      m_drive = nxt;
      m_motor = 1; m_delay = '0;
    end else m_drive = nxt;
  endfunction

  function automatic logic [7:0] bus_access(logic [3:0] off, bit wr, logic [7:0] val);
    bit sense = 0, msb = 0;
    bit d = m_drive;
    logic [7:0] res;
    int nb;
    if (wr && (off == fdc_pkg::SW_LOAD || off == fdc_pkg::SW_WRITE) && m_motor) m_wreq = val;
    if (off < 4'h8) begin
      if (m_motor) begin
        if (off[0]) m_phase[d] = m_phase[d] | (4'b1 << off[2:1]);
        else m_phase[d] = m_phase[d] & ~(4'b1 << off[2:1]);
        move_head();
      end
    end else case (off)
      fdc_pkg::SW_MOTOR_OFF: if (m_motor && !m_off_pend) begin
        m_off_pend = 1; m_off_cnt = '0;
      end
      fdc_pkg::SW_MOTOR_ON: begin
        if (!m_motor) begin m_motor = 1; m_delay = '0; end
        m_off_pend = 0;
      end
      fdc_pkg::SW_DRIVE0: select_drive(0);
      fdc_pkg::SW_DRIVE1: select_drive(1);
      fdc_pkg::SW_SHIFT: if (m_wmode && m_motor && m_present[d]) begin
        nb = m_pos[d] + 1;
        if (nb >= fdc_pkg::BYTES_PER_TRACK) nb = 0;
        m_pw_valid = 1; m_pw_value = m_wreq; m_pw_drive = d;
        m_pw_track = 6'(m_half[d] >> 1); m_pw_byte = 13'(nb);
      end
      fdc_pkg::SW_SENSE: begin
        m_wmode = 0;
        if (m_motor) begin sense = 1; msb = m_wprot[d]; end
      end
      fdc_pkg::SW_WRITE: m_wmode = 1;
      default: ;
    endcase
    res = sense ? {msb, m_latch[6:0]} : m_latch;
    if (m_latch[7]) m_latch = '0;
    return res;
  endfunction

  function automatic void clock_tick();
    bit d = m_drive;
    int idx;
    if (m_delay > 0) begin m_delay--; return; end
    if (m_motor && m_present[d]) begin
      m_pos[d]++;
      if (m_pos[d] >= fdc_pkg::BYTES_PER_TRACK) m_pos[d] = 0;
      if (!m_wmode) begin
        idx = (m_half[d] >> 1) * fdc_pkg::BYTES_PER_TRACK + m_pos[d];
        if (idx < fdc_pkg::SIDE_BYTES)
          m_latch = disk_img.exists(d * fdc_pkg::SIDE_BYTES + idx)
                    ? disk_img[d * fdc_pkg::SIDE_BYTES + idx] : 8'h0;
      end
    end
    if (m_pw_valid) begin
      if (m_present[m_pw_drive]) begin
        idx = int'(m_pw_track) * fdc_pkg::BYTES_PER_TRACK + int'(m_pw_byte);
        if (idx < fdc_pkg::SIDE_BYTES) begin
          disk_img[int'(m_pw_drive) * fdc_pkg::SIDE_BYTES + idx] = m_pw_value;
          m_dirty[m_pw_drive] = 1;
        end
      end
      m_pw_valid = 0; m_pw_value = '0; m_pw_drive = 0; m_pw_track = '0; m_pw_byte = '0;
    end
    if (m_off_pend) begin
      if (m_off_cnt == 16'(fdc_pkg::OFF_DELAY)) begin
        m_off_pend = 0;
        motor_stop();
      end else m_off_cnt = m_off_cnt + 16'd1;
    end
    m_delay = (m_period == 0) ? '0 : m_period - 17'd1;
  endfunction

  function automatic fdc_pkg::rsp_t model_item(fdc_pkg::req_t r);
    fdc_pkg::rsp_t o;
    o.read_data = '0;
    if (r.kind == fdc_pkg::KIND_BUS)
      o.read_data = bus_access(r.switch_offset, r.is_write, r.write_value);
    else if (r.kind == fdc_pkg::KIND_TICK) clock_tick();
    else if (r.kind == fdc_pkg::KIND_LOAD) begin
      if (int'(r.load_address) < fdc_pkg::SIDE_BYTES)
        disk_img[int'(r.load_drive) * fdc_pkg::SIDE_BYTES + int'(r.load_address)] = r.write_value;
    end
    o.motor_on = m_motor;
    o.selected_drive = m_drive;
    o.dirty_flags = {m_dirty[1], m_dirty[0]};
    o.head_position = 7'(m_half[m_drive]);
    return o;
  endfunction

  // ---- driver ----
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (!hold_requests && req_queue.size() > 0 &&
          !(idle_en && $urandom_range(0, 99) < 28)) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= req_queue.pop_front();
      end else in_ch.valid <= 1'b0;
    end
  end

  // ---- monitor ----
  task automatic report(string field, int got, int exp);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, exp, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    fdc_pkg::rsp_t e;
    if (rst) out_ch.ready <= 1'b0;
    else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rsps.size() == 0) report("unexpected result", 1, 0);
        else begin
          e = expected_rsps.pop_front();
          if (out_ch.data.read_data !== e.read_data)
            report("read_data", out_ch.data.read_data, e.read_data);
          if (out_ch.data.motor_on !== e.motor_on)
            report("motor_on", out_ch.data.motor_on, e.motor_on);
          if (out_ch.data.selected_drive !== e.selected_drive)
            report("selected_drive", out_ch.data.selected_drive, e.selected_drive);
          if (out_ch.data.dirty_flags !== e.dirty_flags)
            report("dirty_flags", out_ch.data.dirty_flags, e.dirty_flags);
          if (out_ch.data.head_position !== e.head_position)
            report("head_position", out_ch.data.head_position, e.head_position);
        end
      end
      out_ch.ready <= !(idle_en && $urandom_range(0, 99) < 28);
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  // ---- stimulus ----
  task automatic queue_item(fdc_pkg::req_t r);
    req_queue.push_back(r);
    expected_rsps.push_back(model_item(r));
  endtask

  // An active read tick must only hit store bytes that were loaded before.
  task automatic load_read_target();
    fdc_pkg::req_t ld;
    bit d;
    int nb, addr;
    d = m_drive;
    if (m_delay == 0 && m_motor && m_present[d] && !m_wmode) begin
      nb = m_pos[d] + 1;
      if (nb >= fdc_pkg::BYTES_PER_TRACK) nb = 0;
      addr = (m_half[d] >> 1) * fdc_pkg::BYTES_PER_TRACK + nb;
      if (!disk_img.exists(int'(d) * fdc_pkg::SIDE_BYTES + addr)) begin
        ld.kind = fdc_pkg::KIND_LOAD; ld.switch_offset = 4'($urandom);
        ld.is_write = 1'($urandom); ld.write_value = 8'($urandom);
        ld.load_drive = d; ld.load_address = 18'(addr);
        queue_item(ld);
      end
    end
  endtask

  task automatic push_req(logic [1:0] kind, logic [3:0] off, bit wr, logic [7:0] val,
                          bit drv, logic [17:0] addr);
    fdc_pkg::req_t r;
    r.kind = kind; r.switch_offset = off; r.is_write = wr; r.write_value = val;
    r.load_drive = drv; r.load_address = addr;
    if (kind == fdc_pkg::KIND_TICK) load_read_target();
    queue_item(r);
  endtask

  task automatic push_bus(logic [3:0] off, bit wr, logic [7:0] val);
    push_req(fdc_pkg::KIND_BUS, off, wr, val, 1'($urandom), 18'($urandom));
  endtask

  task automatic push_tick();
    push_req(fdc_pkg::KIND_TICK, 4'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
             18'($urandom));
  endtask

  task automatic drain();
    while (req_queue.size() > 0 || in_ch.valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      fdc_pkg::REG_TICK_PERIOD: m_period = val;
      fdc_pkg::REG_WRITE_PROTECT: m_wprot = val[1:0];
      fdc_pkg::REG_DISK_PRESENT: m_present = val[1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [16:0] period, logic [1:0] wp, logic [1:0] present);
    drain();
    write_reg(fdc_pkg::REG_TICK_PERIOD, period);
    write_reg(fdc_pkg::REG_WRITE_PROTECT, 17'(wp));
    write_reg(fdc_pkg::REG_DISK_PRESENT, 17'(present));
    repeat (2) @(posedge clk);
  endtask

  task automatic random_items(int count);
    int r, p;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) push_tick();
      else if (r < 40)
        push_req(fdc_pkg::KIND_LOAD, 4'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                 18'($urandom_range(0, fdc_pkg::SIDE_BYTES - 1)));
      else if (r < 43)
        push_req(fdc_pkg::KIND_LOAD, 4'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                 18'($urandom_range(fdc_pkg::SIDE_BYTES, 262143)));
      else if (r < 45)
        push_req(KIND_SPARE, 4'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                 18'($urandom));
      else if (r < 62) begin
        // stepper: energize one phase, release the neighbor behind it
        p = $urandom_range(0, 3);
        push_bus(4'(2 * p + 1), 1'($urandom), 8'($urandom));
        push_bus(4'(2 * ((p + 3) % 4)), 1'($urandom), 8'($urandom));
      end else if (r < 72) begin
        push_bus(fdc_pkg::SW_WRITE, 1'b1, 8'($urandom));
        push_bus(fdc_pkg::SW_SHIFT, 1'($urandom), 8'($urandom));
        push_tick();
        if ($urandom_range(0, 1)) push_bus(fdc_pkg::SW_LOAD, 1'b1, 8'($urandom));
      end else if (r < 77) push_bus(fdc_pkg::SW_MOTOR_ON, 1'($urandom), 8'($urandom));
      else if (r < 79) push_bus(fdc_pkg::SW_MOTOR_OFF, 1'($urandom), 8'($urandom));
      else if (r < 82)
        push_bus(4'($urandom_range(fdc_pkg::SW_DRIVE0, fdc_pkg::SW_DRIVE1)), 1'($urandom),
                 8'($urandom));
      else if (r < 86) push_bus(fdc_pkg::SW_SENSE, 1'($urandom), 8'($urandom));
      else push_bus(4'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    model_reset();
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, no disk present so no track reads happen yet
    push_req(KIND_SPARE, 4'hf, 1'b1, 8'hff, 1'b1, 18'h3ffff);
    push_req(fdc_pkg::KIND_LOAD, 4'h0, 1'b0, 8'hff, 1'b1, 18'(fdc_pkg::SIDE_BYTES - 1));
    push_req(fdc_pkg::KIND_LOAD, 4'h0, 1'b0, 8'h00, 1'b0, 18'd0);
    push_req(fdc_pkg::KIND_LOAD, 4'h0, 1'b0, 8'h5a, 1'b0, 18'(fdc_pkg::SIDE_BYTES));
    push_req(fdc_pkg::KIND_LOAD, 4'h0, 1'b0, 8'ha5, 1'b1, 18'h3ffff);
    push_bus(4'h1, 1'b0, 8'h00);
    push_bus(fdc_pkg::SW_MOTOR_ON, 1'b0, 8'h00);
    for (int k = 0; k < 4; k++) push_bus(4'(2 * k + 1), 1'b0, 8'h00);
    for (int k = 0; k < 4; k++) push_bus(4'(2 * k), 1'b1, 8'hff);
    push_bus(4'h7, 1'b0, 8'h00);
    push_bus(4'h6, 1'b0, 8'h00);
    push_bus(fdc_pkg::SW_LOAD, 1'b1, 8'hff);
    push_bus(fdc_pkg::SW_WRITE, 1'b1, 8'h80);
    push_bus(fdc_pkg::SW_SHIFT, 1'b0, 8'h00);
    push_tick();
    push_bus(fdc_pkg::SW_SENSE, 1'b0, 8'h00);
    push_bus(fdc_pkg::SW_DRIVE1, 1'b0, 8'h00);
    push_bus(fdc_pkg::SW_MOTOR_OFF, 1'b0, 8'h00);
    push_bus(fdc_pkg::SW_DRIVE0, 1'b0, 8'h00);
    push_tick();
    push_tick();

    // long stretch without idling on either side
    configure(17'd0, 2'b11, 2'b11);
    idle_en = 1'b0;
    push_bus(fdc_pkg::SW_MOTOR_ON, 1'b0, 8'h00);
    random_items(100);
    drain();
    idle_en = 1'b1;

    configure(17'd1, 2'b01, 2'b01);
    push_bus(fdc_pkg::SW_MOTOR_ON, 1'b0, 8'h00);
    random_items(50);
    while (req_queue.size() > 40) @(posedge clk);
    hold_requests = 1'b1;
    while (in_ch.valid || expected_rsps.size() > req_queue.size()) @(posedge clk);
    hold_requests = 1'b0;
    random_items(50);

    // off request with a staged write committed on the next active tick
    configure(17'd1, 2'b10, 2'b11);
    push_bus(fdc_pkg::SW_MOTOR_ON, 1'b0, 8'h00);
    push_bus(fdc_pkg::SW_WRITE, 1'b1, 8'h3c);
    push_bus(fdc_pkg::SW_SHIFT, 1'b0, 8'h00);
    push_bus(fdc_pkg::SW_MOTOR_OFF, 1'b0, 8'h00);
    for (int k = 0; k < 10; k++) push_tick();
    push_bus(fdc_pkg::SW_MOTOR_ON, 1'b0, 8'h00);

    configure(17'd99999, 2'b10, 2'b10);
    push_bus(fdc_pkg::SW_MOTOR_ON, 1'b0, 8'h00);
    random_items(30);

    configure(17'd3, 2'b00, 2'b11);
    push_bus(fdc_pkg::SW_MOTOR_ON, 1'b0, 8'h00);
    random_items(150);

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
